FILE: design/sorted_hash_table_lookup_core_macros.svh
// Assertion macros for the sorted hash table lookup core checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SORTED_HASH_TABLE_LOOKUP_CORE_MACROS_SVH
`define SORTED_HASH_TABLE_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SHTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SHTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/shtl_pkg.sv
// Shared types and constants of the sorted hash table lookup core.
// No dependencies.
package shtl_pkg;

  localparam int IDX_W      = 12;  // entry_index / match_index
  localparam int CNT_W      = 13;  // num_entries
  localparam int DATA_W     = 32;  // hashes, offsets, addresses
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_BASE = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // write table entry from input item
    logic capture;   // latch key, clear result
    logic start;     // init search bounds, read first midpoint
    logic step;      // evaluate one probe
    logic out_load;  // move result into output register
  } shtl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // search range is empty
    logic match;     // probed hash equals key
    logic more;      // range left after this probe
  } shtl_sts_t;

endpackage

FILE: design/shtl_if.sv
// Valid/ready channel interfaces: lookup input, result output, config writes.
// Depends on shtl_pkg.
interface shtl_in_if import shtl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  entry_index;
  logic [DATA_W-1:0] entry_hash;
  logic [DATA_W-1:0] entry_offset;
  logic [DATA_W-1:0] key_hash;

  modport source (output valid, req_type, entry_index, entry_hash, entry_offset, key_hash,
                  input ready);
  modport sink (input valid, req_type, entry_index, entry_hash, entry_offset, key_hash,
                output ready);
endinterface

interface shtl_out_if import shtl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  match_index;
  logic [DATA_W-1:0] record_address;

  modport source (output valid, found, match_index, record_address, input ready);
  modport sink (input valid, found, match_index, record_address, output ready);
endinterface

interface shtl_cfg_if import shtl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/shtl_ctrl.sv
// Controller FSM: input/output handshakes and search sequencing.
// Depends on shtl_pkg.
module shtl_ctrl import shtl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  shtl_sts_t sts,
  output shtl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.wr_en   = (in_req_type == REQ_LOAD);
          state_nxt   = (in_req_type == REQ_LOAD) ? S_FIN : S_START;
        end
      end
      S_START: begin
        if (sts.empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.step = 1'b1;
        if (sts.match || !sts.more) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for a free output slot
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/shtl_dp.sv
// Datapath: config registers, table memory, search bounds, result and output registers.
// Depends on shtl_pkg.
module shtl_dp import shtl_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [DATA_W-1:0]     in_entry_hash,
  input  logic [DATA_W-1:0]     in_entry_offset,
  input  logic [DATA_W-1:0]     in_key_hash,
  input  shtl_cmd_t             cmd,
  output shtl_sts_t             sts,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_match_index,
  output logic [DATA_W-1:0]     out_record_address
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0]    num_entries_r;
  logic [DATA_W-1:0]   record_base_r;

  logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0] rdata_r;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;

  logic [DATA_W-1:0]   key_r;
  logic [CW-1:0]       lo_r, hi_r, mid_r;
  logic [CW-1:0]       hi_init, mid_init;
  logic [CW-1:0]       lo_nxt, hi_nxt, mid_nxt;
  logic [CW:0]         sum_nxt;
  logic [DATA_W-1:0]   probe_hash;
  logic                hit, ge;

  logic                res_found_r;
  logic [IDX_W-1:0]    res_idx_r;
  logic [DATA_W-1:0]   res_addr_r;
  logic                out_found_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [DATA_W-1:0]   out_addr_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_entries_r <= '0;
      record_base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_ENTRIES: num_entries_r <= cfg_data[CNT_W-1:0];
        REG_RECORD_BASE: record_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // search bounds
  always_comb begin
    if (32'(num_entries_r) > 32'(TABLE_DEPTH)) begin
      hi_init = CW'(TABLE_DEPTH);
    end else begin
      hi_init = CW'(num_entries_r);
    end
    mid_init   = hi_init >> 1;
    probe_hash = rdata_r[2*DATA_W-1:DATA_W];
    hit        = (probe_hash == key_r);
    ge         = (probe_hash >= key_r);
    lo_nxt     = ge ? lo_r : CW'(mid_r + 1'b1);
    hi_nxt     = ge ? mid_r : hi_r;
    sum_nxt    = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt    = sum_nxt[CW:1];
  end

  assign sts.empty = (hi_init == '0);
  assign sts.match = hit;
  assign sts.more  = (lo_nxt < hi_nxt);

  // single-port table: load write, or read of the first or next midpoint
  assign mem_we = cmd.wr_en && (32'(in_entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    priority if (cmd.wr_en) begin
      mem_addr = AW'(in_entry_index);
    end else if (cmd.start) begin
      mem_addr = mid_init[AW-1:0];
    end else begin
      mem_addr = mid_nxt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_entry_hash, in_entry_offset};
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r       <= in_key_hash;
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
      res_addr_r  <= '0;
    end
    if (cmd.start) begin
      lo_r  <= '0;
      hi_r  <= hi_init;
      mid_r <= mid_init;
    end
    if (cmd.step) begin
      if (hit) begin
        res_found_r <= 1'b1;
        res_idx_r   <= IDX_W'(mid_r);
        res_addr_r  <= record_base_r + rdata_r[DATA_W-1:0];
      end else begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        mid_r <= mid_nxt;
      end
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
      out_addr_r  <= res_addr_r;
    end
  end

  assign out_found          = out_found_r;
  assign out_match_index    = out_idx_r;
  assign out_record_address = out_addr_r;

endmodule

FILE: design/sorted_hash_table_lookup_core.sv
// Top level of the sorted hash table lookup core.
// Depends on shtl_pkg, shtl_if, shtl_ctrl and shtl_dp.
//
// Usage:
//  - in_if carries one item at a time. req_type LOAD writes entry_hash and
//    entry_offset at entry_index (ignored if beyond TABLE_DEPTH); LOOKUP
//    binary-searches the first min(num_entries, TABLE_DEPTH) entries for key_hash.
//  - out_if returns one item per input item: found, match_index and
//    record_address (= record_base + offset); all zero on a load or a miss.
//  - cfg_if writes num_entries (index 0) and record_base (index 1); it is
//    always ready and must only be used while the core is idle.
//  - Sequencing: a load goes from idle to the finish state, which moves the
//    result to the output register; a lookup passes the start state and its
//    probes (at most 13 for 4096 entries), each one registered read of the
//    single-port table memory and a compare, so the read loop sets the rate.
//  - The core works on one item at a time; in_if.ready is high only when idle.
//    A finished result sits in the output register, so a new item is taken
//    while the receiver stalls; the following result then waits for the slot.
//  - Reset (rst_n low, synchronous) clears both config registers and the
//    control state. Table contents are not cleared and must be loaded first.
module sorted_hash_table_lookup_core import shtl_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  shtl_in_if.sink     in_if,
  shtl_out_if.source  out_if,
  shtl_cfg_if.sink    cfg_if
);

  shtl_cmd_t cmd;
  shtl_sts_t sts;

  // config writes never stall
  assign cfg_if.ready = 1'b1;

  // sequencing: handshakes, start, one probe per cycle, output slot
  shtl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_if.ready),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // table memory, bounds, compare and result registers
  shtl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_if.valid),
    .cfg_index          (cfg_if.index),
    .cfg_data           (cfg_if.data),
    .in_entry_index     (in_if.entry_index),
    .in_entry_hash      (in_if.entry_hash),
    .in_entry_offset    (in_if.entry_offset),
    .in_key_hash        (in_if.key_hash),
    .cmd                (cmd),
    .sts                (sts),
    .out_found          (out_if.found),
    .out_match_index    (out_if.match_index),
    .out_record_address (out_if.record_address)
  );

endmodule

FILE: design/shtl_chk.sv
// Port-level checker for the sorted hash table lookup core, bound to the top level.
// Depends on shtl_pkg and sorted_hash_table_lookup_core_macros.svh.
`include "sorted_hash_table_lookup_core_macros.svh"

module shtl_chk import shtl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [IDX_W-1:0]  out_match_index,
  input logic [DATA_W-1:0] out_record_address
);

  // stalled result must hold
  `SHTL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_found) && $stable(out_match_index) &&
    $stable(out_record_address), "result changed while stalled")

  // a miss or load reports zero index and address
  `SHTL_ASSERT_NOW(a_miss_zero, out_valid && !out_found,
    out_match_index == '0 && out_record_address == '0, "nonzero fields on a miss")

  // one item at a time: not ready right after taking an item
  `SHTL_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready,
    "input accepted while busy")

endmodule

bind sorted_hash_table_lookup_core shtl_chk u_shtl_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_found          (out_if.found),
  .out_match_index    (out_if.match_index),
  .out_record_address (out_if.record_address)
);
